// ----- src/twco_pkg.sv -----
package twco_pkg;

    localparam int SCREEN_BYTES = 1024;
    localparam int ADDR_W       = $clog2(SCREEN_BYTES);
    localparam int CHAR_W       = 8;
    localparam int ROW_W        = 5;
    localparam int COL_W        = 6;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 8;
    localparam int IN_TDATA_W   = 24;
    localparam int OUT_TDATA_W  = 24;

    localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'hA0;
    localparam logic [CHAR_W-1:0] PRINT_MIN  = 8'hA0;
    localparam logic [CHAR_W-1:0] MASK_RESET = 8'hFF;
    localparam logic [6:0]        CTRL_BS    = 7'h08;
    localparam logic [6:0]        CTRL_LF    = 7'h0A;
    localparam logic [6:0]        CTRL_CR    = 7'h0D;

    localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_TOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_BOTTOM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_MASK   = 3'd4;

    typedef logic [ADDR_W-1:0] t_addr;

    // interleaved text screen layout: row base plus window left plus column
    function automatic t_addr screen_addr(input logic [ROW_W-1:0] row,
                                          input logic [COL_W-1:0] col,
                                          input logic [COL_W-1:0] left);
        logic [1:0] hi;
        logic [7:0] lo;
        logic [7:0] lo5;
        logic [7:0] lo_l;
        hi   = row[2:1];
        lo   = {row[0], 2'b00, row[4:3], 3'b000};
        lo5  = lo + {lo[5:0], 2'b00};
        lo_l = lo5 + {2'b00, left};
        return {hi, lo_l} + {4'b0000, col};
    endfunction

endpackage

// ----- src/twco_ram.sv -----
module twco_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/text_window_char_output_unit.sv -----
// Read item: read issued in S_EXEC, data captured in S_RDQ, result registered in S_DONE.
// Put item without scroll: write in S_EXEC, result registered in S_DONE; a new item is taken in S_IDLE.
// A scroll copies the window up through S_SCR_RD and S_SCR_WR, then blanks its bottom row in S_FILL.
// Reset is synchronous; it restores cursor and window registers, then clears
// all 1024 screen bytes, one per cycle, before the first input transfer.
module text_window_char_output_unit
    import twco_pkg::*;
#(
    parameter int SCREEN_ROWS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // char_code[7:0], read_address[17:8]
    input  logic                   s_axis_tuser,   // mode[0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // read_data[7:0], cursor_row[12:8],
                                                   // cursor_col[18:13], scrolled[19]
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_RDQ    = 3'd3;
    localparam logic [2:0] S_SCR_RD = 3'd4;
    localparam logic [2:0] S_SCR_WR = 3'd5;
    localparam logic [2:0] S_FILL   = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]             r_state, n_state;
    logic [ADDR_W-1:0]      r_clr, n_clr;
    logic [ROW_W-1:0]       r_row, n_row;
    logic [COL_W-1:0]       r_col, n_col;
    logic                   r_out_valid, n_out_valid;

    logic                   r_mode, n_mode;
    logic [CHAR_W-1:0]      r_char, n_char;
    logic [ADDR_W-1:0]      r_raddr, n_raddr;
    logic [CHAR_W-1:0]      r_rdata, n_rdata;
    logic                   r_scr, n_scr;
    logic [ROW_W-1:0]       r_srow, n_srow;
    logic [COL_W-1:0]       r_scol, n_scol;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    logic [COL_W-1:0]       r_win_left;
    logic [COL_W-1:0]       r_win_width;
    logic [ROW_W-1:0]       r_win_top;
    logic [ROW_W-1:0]       r_win_bottom;
    logic [CHAR_W-1:0]      r_inv_mask;

    logic                   mem_we;
    t_addr                  mem_waddr;
    logic [CHAR_W-1:0]      mem_wdata;
    logic                   mem_re;
    t_addr                  mem_raddr;
    logic [CHAR_W-1:0]      mem_rdata;

    logic [ROW_W:0]         row_inc;
    logic [ROW_W:0]         srow_inc;
    logic [COL_W:0]         col_inc;
    logic [ROW_W-1:0]       bot_row;
    logic [ROW_W-1:0]       nl_row;
    logic                   nl_scroll;
    logic                   do_nl;
    logic                   clr_col;

    twco_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (SCREEN_BYTES)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign row_inc  = {1'b0, r_row} + 6'd1;
    assign srow_inc = {1'b0, r_srow} + 6'd1;
    assign col_inc  = {1'b0, r_col} + 7'd1;
    assign bot_row  = r_win_bottom - 5'd1;

    always_comb begin
        if (r_win_bottom <= r_win_top) begin
            nl_row    = r_win_top;
            nl_scroll = 1'b0;
        end else if (row_inc >= {1'b0, r_win_bottom}) begin
            nl_row    = bot_row;
            nl_scroll = 1'b1;
        end else begin
            nl_row    = row_inc[ROW_W-1:0];
            nl_scroll = 1'b0;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_row       = r_row;
        n_col       = r_col;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_mode      = r_mode;
        n_char      = r_char;
        n_raddr     = r_raddr;
        n_rdata     = r_rdata;
        n_scr       = r_scr;
        n_srow      = r_srow;
        n_scol      = r_scol;
        n_out_data  = r_out_data;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        do_nl       = 1'b0;
        clr_col     = 1'b0;

        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                n_clr     = r_clr + ADDR_W'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_mode  = s_axis_tuser;
                    n_char  = s_axis_tdata[7:0];
                    n_raddr = s_axis_tdata[17:8];
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_scr = 1'b0;
                if (r_mode) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_raddr;
                    n_state   = S_RDQ;
                end else begin
                    n_rdata = '0;
                    if (r_char >= PRINT_MIN) begin
                        mem_we    = 1'b1;
                        mem_waddr = screen_addr(r_row, r_col, r_win_left);
                        mem_wdata = r_char & r_inv_mask;
                        if (col_inc >= {1'b0, r_win_width}) begin
                            do_nl   = 1'b1;
                            clr_col = 1'b1;
                        end else begin
                            n_col = col_inc[COL_W-1:0];
                        end
                    end else begin
                        case (r_char[6:0])
                            CTRL_BS: begin
                                if (r_col != '0) begin
                                    n_col = r_col - 6'd1;
                                end
                            end
                            CTRL_LF: begin
                                do_nl = 1'b1;
                            end
                            CTRL_CR: begin
                                do_nl   = 1'b1;
                                clr_col = 1'b1;
                            end
                            default: begin
                            end
                        endcase
                    end
                    if (clr_col) begin
                        n_col = '0;
                    end
                    n_state = S_DONE;
                    if (do_nl) begin
                        n_row = nl_row;
                        n_scr = nl_scroll;
                        if (nl_scroll) begin
                            n_srow  = r_win_top;
                            n_scol  = '0;
                            n_state = S_SCR_RD;
                        end
                    end
                end
            end
            S_RDQ: begin
                n_rdata = mem_rdata;
                n_state = S_DONE;
            end
            S_SCR_RD: begin
                if (srow_inc < {1'b0, r_win_bottom}) begin
                    if (r_scol < r_win_width) begin
                        mem_re    = 1'b1;
                        mem_raddr = screen_addr(srow_inc[ROW_W-1:0], r_scol, r_win_left);
                        n_state   = S_SCR_WR;
                    end else begin
                        n_srow = srow_inc[ROW_W-1:0];
                        n_scol = '0;
                    end
                end else begin
                    n_scol  = '0;
                    n_state = S_FILL;
                end
            end
            S_SCR_WR: begin
                mem_we    = 1'b1;
                mem_waddr = screen_addr(r_srow, r_scol, r_win_left);
                mem_wdata = mem_rdata;
                n_scol    = r_scol + 6'd1;
                n_state   = S_SCR_RD;
            end
            S_FILL: begin
                if (r_scol < r_win_width) begin
                    mem_we    = 1'b1;
                    mem_waddr = screen_addr(bot_row, r_scol, r_win_left);
                    mem_wdata = BLANK_CHAR;
                    n_scol    = r_scol + 6'd1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {4'b0000, r_scr, r_col, r_row, r_rdata};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_row       <= n_row;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_char     <= n_char;
        r_raddr    <= n_raddr;
        r_rdata    <= n_rdata;
        r_scr      <= n_scr;
        r_srow     <= n_srow;
        r_scol     <= n_scol;
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_left   <= '0;
            r_win_width  <= 6'd40;
            r_win_top    <= '0;
            r_win_bottom <= ROW_W'(SCREEN_ROWS);
            r_inv_mask   <= MASK_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WIN_LEFT:   r_win_left   <= i_cfg_data[COL_W-1:0];
                CFG_WIN_WIDTH:  r_win_width  <= i_cfg_data[COL_W-1:0];
                CFG_WIN_TOP:    r_win_top    <= i_cfg_data[ROW_W-1:0];
                CFG_WIN_BOTTOM: r_win_bottom <= i_cfg_data[ROW_W-1:0];
                CFG_INV_MASK:   r_inv_mask   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- tb/sv/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import twco_pkg::*;

    localparam bit            MODE_PUT       = 1'b0;
    localparam bit            MODE_READ      = 1'b1;
    localparam logic [7:0]    CHAR_BELL      = 8'h87;
    localparam int            ITEM_TARGET    = 1150;
    localparam int            WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [7:0] read_data;
        logic [4:0] cursor_row;
        logic [5:0] cursor_col;
        logic       scrolled;
    } t_report;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // char_code[7:0], read_address[17:8]
    logic                   s_axis_tuser  = 1'b0; // mode[0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // read_data[7:0], cursor_row[12:8],
                                                  // cursor_col[18:13], scrolled[19]

    logic [7:0] screen_mem [SCREEN_BYTES];
    logic [4:0] cur_row    = '0;
    logic [5:0] cur_col    = '0;
    logic [5:0] win_left   = 6'd0;
    logic [5:0] win_width  = 6'd40;
    logic [4:0] win_top    = 5'd0;
    logic [4:0] win_bottom = 5'd24;
    logic [7:0] char_mask  = MASK_RESET;

    t_report pending_reports [$];

    int items_sent      = 0;
    int reads_sent      = 0;
    int scrolls_seen    = 0;
    int results_checked = 0;
    int settings_count  = 0;
    int mismatches      = 0;
    int burst_left      = 0;
    int quiet_cycles    = 0;
    int unsigned stall_timer = 0;
    int stall_style     = 0;

    text_window_char_output_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [ADDR_W-1:0] text_addr(input int r, input int c);
        int lo;
        lo = (r & 'h18) + (((r & 1) != 0) ? 'h80 : 0);
        lo = ((lo * 5) + win_left) & 'hFF;
        return ADDR_W'((((r >> 1) & 3) << 8) + lo + c);
    endfunction

    function automatic void scroll_window_up();
        for (int r = win_top; r + 1 < win_bottom; r++)
            for (int c = 0; c < win_width; c++)
                screen_mem[text_addr(r, c)] = screen_mem[text_addr(r + 1, c)];
        for (int c = 0; c < win_width; c++)
            screen_mem[text_addr(win_bottom - 1, c)] = BLANK_CHAR;
    endfunction

    function automatic bit advance_line(input bit clear_col);
        if (clear_col)
            cur_col = '0;
        if (win_bottom <= win_top) begin
            cur_row = win_top;
            return 1'b0;
        end
        if (int'(cur_row) + 1 >= int'(win_bottom)) begin
            scroll_window_up();
            cur_row = win_bottom - 5'd1;
            return 1'b1;
        end
        cur_row = cur_row + 5'd1;
        return 1'b0;
    endfunction

    function automatic t_report apply_char_output(input bit mode, input logic [7:0] ch,
                                                  input logic [ADDR_W-1:0] addr);
        t_report rep;
        rep = '0;
        if (mode == MODE_READ) begin
            rep.read_data = screen_mem[addr];
        end else if (ch >= PRINT_MIN) begin
            screen_mem[text_addr(cur_row, cur_col)] = ch & char_mask;
            if (int'(cur_col) + 1 >= int'(win_width))
                rep.scrolled = advance_line(1'b1);
            else
                cur_col = cur_col + 6'd1;
        end else begin
            case (ch[6:0])
                CTRL_BS: begin
                    if (cur_col != 0)
                        cur_col = cur_col - 6'd1;
                end
                CTRL_LF: rep.scrolled = advance_line(1'b0);
                CTRL_CR: rep.scrolled = advance_line(1'b1);
                default: ;
            endcase
        end
        rep.cursor_row = cur_row;
        rep.cursor_col = cur_col;
        return rep;
    endfunction

    function automatic logic [7:0] random_char(input int nl_pct);
        int   pick;
        logic hi;
        pick = $urandom_range(0, 99);
        hi   = 1'($urandom_range(0, 1));
        if (pick < nl_pct)
            return {hi, (pick % 2 == 0) ? CTRL_LF : CTRL_CR};
        if (pick < nl_pct + 8)
            return {hi, CTRL_BS};
        if (pick < nl_pct + 14)
            return 8'($urandom_range(0, PRINT_MIN - 1));
        return 8'($urandom_range(PRINT_MIN, 255));
    endfunction

    task automatic send_item(input bit mode, input logic [7:0] ch,
                             input logic [ADDR_W-1:0] addr);
        t_report rep;
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {{(IN_TDATA_W - ADDR_W - CHAR_W){1'b0}}, addr, ch};
        do @(posedge i_clk); while (!s_axis_tready);
        rep = apply_char_output(mode, ch, addr);
        pending_reports.push_back(rep);
        items_sent++;
        if (mode == MODE_READ)
            reads_sent++;
        if (rep.scrolled)
            scrolls_seen++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_window(input logic [5:0] new_left, input logic [5:0] new_width,
                              input logic [4:0] new_top, input logic [4:0] new_bottom,
                              input logic [7:0] new_mask);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_WIN_LEFT;
        i_cfg_data <= CFG_DATA_W'(new_left);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_WIN_WIDTH;
        i_cfg_data <= CFG_DATA_W'(new_width);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_WIN_TOP;
        i_cfg_data <= CFG_DATA_W'(new_top);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_WIN_BOTTOM;
        i_cfg_data <= CFG_DATA_W'(new_bottom);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_INV_MASK;
        i_cfg_data <= new_mask;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        win_left   = new_left;
        win_width  = new_width;
        win_top    = new_top;
        win_bottom = new_bottom;
        char_mask  = new_mask;
        settings_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t %s mismatch: expected %0h actual %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    task automatic test_put_and_controls();
        send_item(MODE_READ, 8'h00, 10'h000);
        send_item(MODE_READ, 8'hFF, 10'h3FF);
        send_item(MODE_PUT, 8'hC1, 10'h3FF);
        send_item(MODE_PUT, 8'hFF, 10'h000);
        send_item(MODE_PUT, PRINT_MIN - 8'd1, 10'h155);
        send_item(MODE_PUT, CHAR_BELL, 10'h2AA);
        send_item(MODE_PUT, {1'b0, CTRL_BS}, 10'h000);
        send_item(MODE_PUT, {1'b1, CTRL_BS}, 10'h3FF);
        // backspace at column zero holds the column
        send_item(MODE_PUT, {1'b1, CTRL_BS}, 10'h000);
        send_item(MODE_PUT, {1'b1, CTRL_LF}, 10'h3FF);
        send_item(MODE_PUT, {1'b0, CTRL_CR}, 10'h000);
        send_item(MODE_PUT, {1'b1, CTRL_CR}, 10'h3FF);
        set_window(6'd0, 6'd40, 5'd0, 5'd24, 8'h3F);
        send_item(MODE_PUT, 8'hFF, 10'h000);
        send_item(MODE_READ, 8'h5A, text_addr(cur_row, 0));
    endtask

    task automatic test_window_extremes();
        set_window(6'd39, 6'd1, 5'd23, 5'd24, 8'h7F);
        send_item(MODE_PUT, 8'hE5, 10'h000);
        send_item(MODE_PUT, PRINT_MIN, 10'h3FF);
        send_item(MODE_READ, 8'hA5, text_addr(23, 0));
        // empty window: every newline parks on the top row
        set_window(6'd63, 6'd0, 5'd31, 5'd31, 8'h00);
        send_item(MODE_PUT, 8'hFF, 10'h000);
        send_item(MODE_PUT, {1'b0, CTRL_LF}, 10'h3FF);
        // widest and tallest window: one full-size scroll
        set_window(6'd0, 6'd63, 5'd0, 5'd31, 8'h3F);
        send_item(MODE_PUT, {1'b0, CTRL_LF}, 10'h000);
        send_item(MODE_PUT, 8'hDA, 10'h3FF);
        set_window(6'd20, 6'd40, 5'd5, 5'd0, MASK_RESET);
        send_item(MODE_PUT, {1'b0, CTRL_CR}, 10'h000);
    endtask

    task automatic test_random_text();
        int         phase;
        int         n;
        int         nl_pct;
        int         t;
        logic [7:0] mask;
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 3))
                0:       mask = 8'h3F;
                1:       mask = 8'h7F;
                2:       mask = MASK_RESET;
                default: mask = 8'($urandom_range(0, 255));
            endcase
            nl_pct = 12;
            if (phase == 3) begin
                set_window(6'd0, 6'd40, 5'd0, 5'd24, mask);
                n      = 80;
                nl_pct = 35;
            end else if (phase == 7) begin
                set_window(6'($urandom_range(0, 63)), 6'd63, 5'd0, 5'd31, mask);
                n      = 16;
                nl_pct = 35;
            end else begin
                case ($urandom_range(0, 7))
                    0: begin
                        t = $urandom_range(0, 31);
                        set_window(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                                   5'(t), 5'($urandom_range(0, t)), mask);
                    end
                    1: begin
                        t = $urandom_range(20, 28);
                        set_window(6'($urandom_range(40, 63)),
                                   ($urandom_range(0, 1) == 1) ? 6'd0
                                                               : 6'($urandom_range(41, 63)),
                                   5'(t), 5'(t + $urandom_range(1, 3)), mask);
                    end
                    default: begin
                        t = $urandom_range(0, 22);
                        set_window(6'($urandom_range(0, 39)), 6'($urandom_range(1, 8)),
                                   5'(t), 5'((t + $urandom_range(1, 4) > 24) ? 24
                                             : t + $urandom_range(1, 4)), mask);
                    end
                endcase
                n = $urandom_range(20, 60);
            end
            repeat (n) begin
                if ($urandom_range(0, 3) == 0)
                    send_item(MODE_READ, 8'($urandom_range(0, 255)),
                              ($urandom_range(0, 1) == 1)
                                  ? text_addr(cur_row, $urandom_range(0, win_width))
                                  : ADDR_W'($urandom_range(0, SCREEN_BYTES - 1)));
                else
                    send_item(MODE_PUT, random_char(nl_pct),
                              ADDR_W'($urandom_range(0, SCREEN_BYTES - 1)));
            end
            phase++;
        end
    endtask

    always @(posedge i_clk) begin
        if (stall_timer == 0) begin
            stall_style <= $urandom_range(0, 3);
            stall_timer <= $urandom_range(16, 128);
        end else begin
            stall_timer <= stall_timer - 1;
        end
        case (stall_style)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            2:       m_axis_tready <= ($urandom_range(0, 1) == 1);
            default: m_axis_tready <= ((stall_timer % 8) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_report want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_checked++;
            if (pending_reports.size() == 0) begin
                $display("%0t unexpected transfer: expected none actual %h", $time,
                         m_axis_tdata);
                mismatches++;
            end else begin
                want = pending_reports.pop_front();
                check_field("read_data", want.read_data, m_axis_tdata[7:0]);
                check_field("cursor_row", want.cursor_row, m_axis_tdata[12:8]);
                check_field("cursor_col", want.cursor_col, m_axis_tdata[18:13]);
                check_field("scrolled", want.scrolled, m_axis_tdata[19]);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t timeout: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        foreach (screen_mem[i])
            screen_mem[i] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_put_and_controls();
        test_window_extremes();
        test_random_text();
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (pending_reports.size() != 0) begin
            $display("%0t %0d results never arrived", $time, pending_reports.size());
            mismatches++;
        end
        $display("Sent %0d items (%0d screen reads, %0d scrolls) over %0d window settings",
                 items_sent, reads_sent, scrolls_seen, settings_count);
        $display("Compared %0d results, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
src/twco_pkg.sv
src/twco_ram.sv
src/text_window_char_output_unit.sv
tb/sv/tb.sv
